// File: rtl/psd_pkg.sv
`default_nettype none

package psd_pkg;

    localparam int MAX_ROWS    = 64;
    localparam int MAX_COLUMNS = 1024;

    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int COL_W   = $clog2(MAX_COLUMNS);
    localparam int ADDR_W  = ROW_W + COL_W;
    localparam int SYM_W   = 8;
    localparam int WGT_W   = 16;
    localparam int NCOL_W  = 11;
    localparam int DIST_W  = 26;
    localparam int CFG_W   = 11;

    localparam logic [DIST_W-1:0] DIST_MAX   = {DIST_W{1'b1}};
    localparam logic [NCOL_W-1:0] COL_LIMIT  = NCOL_W'(MAX_COLUMNS);
    localparam logic [NCOL_W-1:0] NCOL_RESET = NCOL_W'(1);

    typedef enum logic [1:0]
    {
        OP_LOAD_WEIGHT = 2'd0,
        OP_LOAD_SYMBOL = 2'd1,
        OP_QUERY       = 2'd2
    } psd_op_t;

    typedef enum logic
    {
        CFG_NUM_COLUMNS = 1'b0,
        CFG_METRIC_MODE = 1'b1
    } psd_cfg_idx_t;

    typedef struct packed
    {
        logic [1:0]       op;
        logic [5:0]       row_a;
        logic [5:0]       row_b;
        logic [9:0]       column;
        logic [SYM_W-1:0] symbol;
        logic [WGT_W-1:0] weight;
    } psd_in_t;

    typedef struct packed
    {
        logic [5:0]        first_row;
        logic [5:0]        second_row;
        logic [DIST_W-1:0] distance;
    } psd_out_t;

endpackage

`default_nettype wire

// File: rtl/psd_ram.sv
`default_nettype none

module psd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: rtl/pairwise_sequence_distance_top.sv
// Channel   Direction  Handshake             Payload
// in        input      in_valid / in_stall   in_data   (psd_in_t)
// out       output     out_valid / out_stall out_data  (psd_out_t)
// cfg       input      cfg_wr_en             cfg_index, cfg_data
//
// A load beat writes its store when it is accepted. A query beat walks N columns,
// where N is num_columns limited to MAX_COLUMNS; one shared compare and add unit
// handles one column per cycle behind the registered reads of the stores.
// Reset clears only control state; the stores are not cleared.
// A finished result waits in the output register while out_stall is high,
// and load beats are still taken meanwhile unless a query is in progress.
`default_nettype none

module pairwise_sequence_distance_top
    import psd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire psd_in_t           in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output psd_out_t               out_data,
    input  wire logic              cfg_wr_en,
    input  wire logic              cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_data
);

    typedef enum logic [3:0]
    {
        ST_IDLE  = 4'b0001,
        ST_RUN   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [NCOL_W-1:0]   num_columns_reg;
    logic                metric_mode_reg;
    logic [ROW_W-1:0]    row_a_reg, row_a_next;
    logic [ROW_W-1:0]    row_b_reg, row_b_next;
    logic [5:0]          first_row_reg, first_row_next;
    logic [5:0]          second_row_reg, second_row_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [COL_W-1:0]    last_reg, last_next;
    logic [DIST_W-1:0]   acc_reg, acc_next;
    logic                rd_valid_reg;
    logic                out_valid_reg, out_valid_next;
    psd_out_t            out_data_reg, out_data_next;

    logic                in_accept;
    logic                out_load;
    logic [NCOL_W-1:0]   n_cols;
    logic                sym_wr_en;
    logic                wgt_wr_en;
    logic                rd_en;
    logic [ADDR_W-1:0]   sym_wr_addr;
    logic [ADDR_W-1:0]   rd_addr_a;
    logic [ADDR_W-1:0]   rd_addr_b;
    logic [SYM_W-1:0]    sym_a;
    logic [SYM_W-1:0]    sym_b;
    logic [WGT_W-1:0]    wgt;
    logic [SYM_W-1:0]    abs_diff;
    logic [WGT_W-1:0]    term;
    logic [DIST_W:0]     sum;

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign sym_wr_en   = in_accept && (in_data.op == OP_LOAD_SYMBOL);
    assign wgt_wr_en   = in_accept && (in_data.op == OP_LOAD_WEIGHT);
    assign sym_wr_addr = {in_data.row_a[ROW_W-1:0], in_data.column[COL_W-1:0]};
    assign rd_en       = (state_reg == ST_RUN);
    assign rd_addr_a   = {row_a_reg, col_reg};
    assign rd_addr_b   = {row_b_reg, col_reg};

    // Each row store copy serves one of the two rows of a query.
    psd_ram #(.WIDTH(SYM_W), .DEPTH(MAX_ROWS * MAX_COLUMNS)) u_sym_a (
        .clk     (clk),
        .wr_en   (sym_wr_en),
        .wr_addr (sym_wr_addr),
        .wr_data (in_data.symbol),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_a),
        .rd_data (sym_a)
    );

    psd_ram #(.WIDTH(SYM_W), .DEPTH(MAX_ROWS * MAX_COLUMNS)) u_sym_b (
        .clk     (clk),
        .wr_en   (sym_wr_en),
        .wr_addr (sym_wr_addr),
        .wr_data (in_data.symbol),
        .rd_en   (rd_en),
        .rd_addr (rd_addr_b),
        .rd_data (sym_b)
    );

    psd_ram #(.WIDTH(WGT_W), .DEPTH(MAX_COLUMNS)) u_wgt (
        .clk     (clk),
        .wr_en   (wgt_wr_en),
        .wr_addr (in_data.column[COL_W-1:0]),
        .wr_data (in_data.weight),
        .rd_en   (rd_en),
        .rd_addr (col_reg),
        .rd_data (wgt)
    );

    always_comb
    begin
        abs_diff = (sym_a > sym_b) ? (sym_a - sym_b) : (sym_b - sym_a);
        if (metric_mode_reg)
        begin
            term = WGT_W'(abs_diff);
        end
        else if (sym_a != sym_b)
        begin
            term = wgt;
        end
        else
        begin
            term = '0;
        end
        sum = {1'b0, acc_reg} + (DIST_W + 1)'(term);
    end

    assign n_cols   = (num_columns_reg > COL_LIMIT) ? COL_LIMIT : num_columns_reg;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next      = state_reg;
        row_a_next      = row_a_reg;
        row_b_next      = row_b_reg;
        first_row_next  = first_row_reg;
        second_row_next = second_row_reg;
        col_next        = col_reg;
        last_next       = last_reg;
        acc_next        = acc_reg;

        if (rd_valid_reg)
        begin
            acc_next = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (in_data.op == OP_QUERY))
                begin
                    row_a_next      = in_data.row_a[ROW_W-1:0];
                    row_b_next      = in_data.row_b[ROW_W-1:0];
                    first_row_next  = in_data.row_a;
                    second_row_next = in_data.row_b;
                    col_next        = '0;
                    last_next       = COL_W'(n_cols - NCOL_W'(1));
                    acc_next        = '0;
                    state_next      = (n_cols == '0) ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (col_reg == last_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    col_next = col_reg + COL_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        if (out_load)
        begin
            out_valid_next           = 1'b1;
            out_data_next.first_row  = first_row_reg;
            out_data_next.second_row = second_row_reg;
            out_data_next.distance   = acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            rd_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            num_columns_reg <= NCOL_RESET;
            metric_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_valid_reg  <= rd_en;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_NUM_COLUMNS: num_columns_reg <= cfg_data[NCOL_W-1:0];
                    CFG_METRIC_MODE: metric_mode_reg <= cfg_data[0];
                    default:         metric_mode_reg <= metric_mode_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        row_a_reg      <= row_a_next;
        row_b_reg      <= row_b_next;
        first_row_reg  <= first_row_next;
        second_row_reg <= second_row_next;
        col_reg        <= col_next;
        last_reg       <= last_next;
        acc_reg        <= acc_next;
        out_data_reg   <= out_data_next;
    end

    a_acc_cleared_on_query: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (in_data.op == OP_QUERY)) |=> (acc_reg == '0))
        else $error("accumulator not cleared at query start");

    a_read_data_in_walk: assert property (@(posedge clk) disable iff (!rst_n)
        rd_valid_reg |-> ((state_reg == ST_RUN) || (state_reg == ST_DRAIN)))
        else $error("read data arrived outside a column walk");

    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !out_load)
        else $error("pending result overwritten");

    a_drain_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN) |=> (state_reg == ST_DONE))
        else $error("drain did not end in done");

endmodule

`default_nettype wire
